// ===== src/lab_pkg.sv =====
package lab_pkg;

	localparam int COORD_W  = 16;
	localparam int UNIT_W   = 16;
	localparam int UNIT_ONE = 16384;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [UNIT_W-1:0]  unit_t;
	typedef logic [1:0]                cfg_addr_t;

	typedef enum logic [1:0] {
		CFG_UP_X = 2'd0,
		CFG_UP_Y = 2'd1,
		CFG_UP_Z = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		coord_t eye_x;
		coord_t eye_y;
		coord_t eye_z;
		coord_t target_x;
		coord_t target_y;
		coord_t target_z;
	} src_t;

	typedef struct packed {
		unit_t right_x;
		unit_t right_y;
		unit_t right_z;
		unit_t ortho_up_x;
		unit_t ortho_up_y;
		unit_t ortho_up_z;
		unit_t fwd_x;
		unit_t fwd_y;
		unit_t fwd_z;
		logic  degenerate;
	} res_t;

endpackage

// ===== src/lab_cross.sv =====
module lab_cross #(
	parameter int A_W   = 16,
	parameter int B_W   = 16,
	parameter int TAG_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     valid,
	input  logic signed [A_W-1:0]    ax,
	input  logic signed [A_W-1:0]    ay,
	input  logic signed [A_W-1:0]    az,
	input  logic signed [B_W-1:0]    bx,
	input  logic signed [B_W-1:0]    by,
	input  logic signed [B_W-1:0]    bz,
	input  logic [TAG_W-1:0]         tag,
	output logic                     c_valid,
	output logic signed [A_W+B_W:0]  cx,
	output logic signed [A_W+B_W:0]  cy,
	output logic signed [A_W+B_W:0]  cz,
	output logic [TAG_W-1:0]         c_tag
);
	import lab_pkg::*;

	localparam int PW = A_W + B_W;

	logic signed [PW-1:0] p_s1 [6];
	logic [TAG_W-1:0]     tag_s1;
	logic signed [PW:0]   c_s2 [3];
	logic [TAG_W-1:0]     tag_s2;
	logic [2:1]           vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[1], valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= ay * bz;
			p_s1[1] <= az * by;
			p_s1[2] <= az * bx;
			p_s1[3] <= ax * bz;
			p_s1[4] <= ax * by;
			p_s1[5] <= ay * bx;
			tag_s1  <= tag;
			c_s2[0] <= (PW+1)'(p_s1[0]) - (PW+1)'(p_s1[1]);
			c_s2[1] <= (PW+1)'(p_s1[2]) - (PW+1)'(p_s1[3]);
			c_s2[2] <= (PW+1)'(p_s1[4]) - (PW+1)'(p_s1[5]);
			tag_s2  <= tag_s1;
		end
	end

	assign c_valid = vld_s[2];
	assign cx      = c_s2[0];
	assign cy      = c_s2[1];
	assign cz      = c_s2[2];
	assign c_tag   = tag_s2;

endmodule

// ===== src/lab_unit.sv =====
module lab_unit #(
	parameter int IN_W  = 17,
	parameter int TAG_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid,
	input  logic signed [IN_W-1:0] x,
	input  logic signed [IN_W-1:0] y,
	input  logic signed [IN_W-1:0] z,
	input  logic [TAG_W-1:0]       tag,
	output logic                   u_valid,
	output lab_pkg::unit_t         ux,
	output lab_pkg::unit_t         uy,
	output lab_pkg::unit_t         uz,
	output logic                   nz,
	output logic [TAG_W-1:0]       u_tag
);
	import lab_pkg::*;

	// for a nonzero vector the largest normalized magnitude lies in [2^(MW-1), 2^MW), the others below 2^MW
	localparam int MW      = 20;
	localparam int WW      = (IN_W > MW) ? IN_W : MW;
	localparam int PW      = $clog2(WW);
	localparam int SW      = 2 * MW + 2;
	localparam int RN      = MW + 1;
	localparam int RW      = RN + 2;
	localparam int FB      = 15;
	localparam int QN      = UNIT_W - 1;
	localparam int NW      = MW + FB + 1;
	localparam int DRW     = RN + 1;
	localparam int NEG_LSB = 3 * MW;
	localparam int NZ_BIT  = 3 * MW + 3;
	localparam int TAG_LSB = 3 * MW + 4;
	localparam int SDW     = 3 * MW + 4 + TAG_W;
	localparam int SQ0     = 5;
	localparam int DV0     = SQ0 + RN + 1;
	localparam int DVL     = DV0 + QN;
	localparam int LAST    = DVL + 1;

	logic [IN_W-1:0]  vin [3];
	logic [IN_W-1:0]  mag [3];
	logic [IN_W-1:0]  a_s1 [3];
	logic [2:0]       neg_s1;
	logic [TAG_W-1:0] tag_s1;
	logic [IN_W-1:0]  a_s2 [3];
	logic [2:0]       neg_s2;
	logic [TAG_W-1:0] tag_s2;
	logic             nz_s2;
	logic [PW-1:0]    p_s2;
	logic [WW-1:0]    or_all;
	logic [PW-1:0]    pe;
	logic [WW-1:0]    ext [3];
	logic [MW-1:0]    sh [3];

	logic [SDW-1:0]   side_s [3:DVL];
	logic [2*MW-1:0]  sqr_s4 [3];

	logic [RN-1:0]    rem_s  [SQ0:SQ0+RN-1];
	logic [RN-1:0]    root_s [SQ0:SQ0+RN];
	logic [SW-1:0]    rad_s  [SQ0:SQ0+RN-1];
	logic [RW-1:0]    n_rem  [1:RN];
	logic [RN-1:0]    n_root [1:RN];
	logic [SW-1:0]    n_rad  [1:RN];
	logic [RW-1:0]    cur;
	logic [RW-1:0]    trial;

	logic [NW-1:0]    nn [3];
	logic [DRW-1:0]   dsr_s  [DV0:DVL];
	logic [DRW-1:0]   drem_s [3][DV0:DVL];
	logic [FB-1:0]    dlo_s  [3][DV0:DVL];
	logic [QN-1:0]    q_s    [3][DV0:DVL];
	logic [DRW-1:0]   n_drem [3][1:QN];
	logic [FB-1:0]    n_dlo  [3][1:QN];
	logic [QN-1:0]    n_q    [3][1:QN];
	logic [DRW:0]     dcur;

	logic [QN-1:0]    qc [3];
	logic [UNIT_W-1:0] qe [3];
	unit_t            fin_s [3];
	logic             nz_f;
	logic [TAG_W-1:0] tag_f;
	logic [LAST:1]    vld_s;

	assign vin[0] = x;
	assign vin[1] = y;
	assign vin[2] = z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vin[i][IN_W-1] ? (~vin[i] + IN_W'(1)) : vin[i];
		end
		or_all = WW'(a_s1[0] | a_s1[1] | a_s1[2]);
		pe = '0;
		for (int b = 0; b < WW; b++) begin
			if (or_all[b]) begin
				pe = PW'(b);
			end
		end
		for (int i = 0; i < 3; i++) begin
			ext[i] = WW'(a_s2[i]);
			if (p_s2 >= PW'(MW - 1)) begin
				ext[i] = ext[i] >> (p_s2 - PW'(MW - 1));
			end else begin
				ext[i] = ext[i] << (PW'(MW - 1) - p_s2);
			end
			sh[i] = ext[i][MW-1:0];
		end
	end

	// digit-by-digit square root, one result bit per stage
	always_comb begin
		cur   = '0;
		trial = '0;
		for (int k = 1; k <= RN; k++) begin
			cur      = {rem_s[SQ0+k-1], rad_s[SQ0+k-1][SW-1 -: 2]};
			trial    = {root_s[SQ0+k-1], 2'b01};
			n_rad[k] = rad_s[SQ0+k-1] << 2;
			if (cur >= trial) begin
				n_rem[k]  = cur - trial;
				n_root[k] = {root_s[SQ0+k-1][RN-2:0], 1'b1};
			end else begin
				n_rem[k]  = cur;
				n_root[k] = {root_s[SQ0+k-1][RN-2:0], 1'b0};
			end
		end
	end

	// restoring division, one quotient bit per stage
	always_comb begin
		dcur = '0;
		for (int i = 0; i < 3; i++) begin
			nn[i] = (NW'(side_s[DV0-1][i*MW +: MW]) << FB) + NW'(root_s[SQ0+RN]);
			for (int j = 1; j <= QN; j++) begin
				dcur        = {drem_s[i][DV0+j-1], dlo_s[i][DV0+j-1][FB-1]};
				n_dlo[i][j] = dlo_s[i][DV0+j-1] << 1;
				if (dcur >= {1'b0, dsr_s[DV0+j-1]}) begin
					dcur      = dcur - {1'b0, dsr_s[DV0+j-1]};
					n_q[i][j] = {q_s[i][DV0+j-1][QN-2:0], 1'b1};
				end else begin
					n_q[i][j] = {q_s[i][DV0+j-1][QN-2:0], 1'b0};
				end
				n_drem[i][j] = dcur[DRW-1:0];
			end
			qc[i] = (q_s[i][DVL] > QN'(UNIT_ONE)) ? QN'(UNIT_ONE) : q_s[i][DVL];
			qe[i] = {1'b0, qc[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST-1:1], valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i]   <= mag[i];
				neg_s1[i] <= vin[i][IN_W-1];
				a_s2[i]   <= a_s1[i];
				sqr_s4[i] <= side_s[3][i*MW +: MW] * side_s[3][i*MW +: MW];
			end
			tag_s1 <= tag;
			neg_s2 <= neg_s1;
			tag_s2 <= tag_s1;
			nz_s2  <= |or_all;
			p_s2   <= pe;

			side_s[3] <= {tag_s2, nz_s2, neg_s2, sh[2], sh[1], sh[0]};
			for (int k = 4; k <= DVL; k++) begin
				side_s[k] <= side_s[k-1];
			end

			rad_s[SQ0]  <= SW'(sqr_s4[0]) + SW'(sqr_s4[1]) + SW'(sqr_s4[2]);
			rem_s[SQ0]  <= '0;
			root_s[SQ0] <= '0;
			for (int k = 1; k <= RN; k++) begin
				root_s[SQ0+k] <= n_root[k];
				if (k < RN) begin
					rem_s[SQ0+k] <= n_rem[k][RN-1:0];
					rad_s[SQ0+k] <= n_rad[k];
				end
			end

			dsr_s[DV0] <= {root_s[SQ0+RN], 1'b0};
			for (int j = 1; j <= QN; j++) begin
				dsr_s[DV0+j] <= dsr_s[DV0+j-1];
			end
			for (int i = 0; i < 3; i++) begin
				drem_s[i][DV0] <= DRW'(nn[i][NW-1:FB]);
				dlo_s[i][DV0]  <= nn[i][FB-1:0];
				q_s[i][DV0]    <= '0;
				for (int j = 1; j <= QN; j++) begin
					drem_s[i][DV0+j] <= n_drem[i][j];
					dlo_s[i][DV0+j]  <= n_dlo[i][j];
					q_s[i][DV0+j]    <= n_q[i][j];
				end
				fin_s[i] <= side_s[DVL][NEG_LSB+i] ? unit_t'(~qe[i] + UNIT_W'(1))
					: unit_t'(qe[i]);
			end
			nz_f  <= side_s[DVL][NZ_BIT];
			tag_f <= side_s[DVL][TAG_LSB +: TAG_W];
		end
	end

	assign u_valid = vld_s[LAST];
	assign ux      = fin_s[0];
	assign uy      = fin_s[1];
	assign uz      = fin_s[2];
	assign nz      = nz_f;
	assign u_tag   = tag_f;

endmodule

// ===== src/look_at_basis.sv =====
// look_at_basis: camera basis (forward, right, second up) from eye and target.
// Input channel src_valid / src_stall / src_data carries eye and target points
// in signed Q4.12; a transfer happens when src_valid is high and src_stall low.
// Output channel res_valid / res_stall / res_data carries right, ortho_up and
// fwd in signed Q2.14 plus the degenerate flag; one result per input item.
// Config channel cfg_valid / cfg_ready / cfg_index / cfg_data writes the up
// vector (index 0..2, Q4.12); cfg_ready is always high, other indexes are
// ignored. Write config only while no item is in flight.
// The pipe is a difference stage, then three unit-vector pipelines
// of 43 stages each (21 square-root stages, 15 divider stages), two 2-stage
// cross products and the output register.
// Throughput is one item per cycle when not held. All stages advance together;
// the whole pipe holds while a result sits in the output register and res_stall
// is high, and src_stall follows that hold. Empty slots do not block.
// Reset clears all valid bits and sets the up vector to (0, 1.0, 0).
module look_at_basis (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  lab_pkg::src_t      src_data,
	output logic               res_valid,
	input  logic               res_stall,
	output lab_pkg::res_t      res_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  lab_pkg::cfg_addr_t cfg_index,
	input  lab_pkg::coord_t    cfg_data
);
	import lab_pkg::*;

	localparam int DW  = COORD_W + 1;
	localparam int C1W = COORD_W + UNIT_W + 1;
	localparam int C2W = 2 * UNIT_W + 1;
	localparam int T1W = 3 * UNIT_W + 1;
	localparam int T2W = 6 * UNIT_W + 1;

	logic en;
	coord_t up_x_q, up_y_q, up_z_q;

	logic                  d_valid_s1;
	logic signed [DW-1:0]  dx_s1, dy_s1, dz_s1;

	logic                  f_valid, f_nz;
	unit_t                 fx, fy, fz;
	logic [0:0]            f_tag;

	logic                  c1_valid;
	logic signed [C1W-1:0] c1x, c1y, c1z;
	logic [T1W-1:0]        c1_tag;

	logic                  r_valid, r_nz;
	unit_t                 rx, ry, rz;
	logic [T1W-1:0]        r_tag;
	logic                  r_ok;

	logic                  c2_valid;
	logic signed [C2W-1:0] c2x, c2y, c2z;
	logic [T2W-1:0]        c2_tag;

	logic                  n_valid, n_nz;
	unit_t                 nx, ny, nz;
	logic [T2W-1:0]        n_tag;
	logic                  ok;

	logic                  res_valid_q;
	res_t                  res_q;

	assign en        = !res_valid_q || !res_stall;
	assign src_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_x_q <= coord_t'(0);
			up_y_q <= coord_t'(4096);
			up_z_q <= coord_t'(0);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_UP_X: up_x_q <= cfg_data;
				CFG_UP_Y: up_y_q <= cfg_data;
				CFG_UP_Z: up_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_valid_s1  <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			d_valid_s1  <= src_valid;
			res_valid_q <= n_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DW'(src_data.target_x) - DW'(src_data.eye_x);
			dy_s1 <= DW'(src_data.target_y) - DW'(src_data.eye_y);
			dz_s1 <= DW'(src_data.target_z) - DW'(src_data.eye_z);
		end
	end

	lab_unit #(.IN_W(DW), .TAG_W(1)) u_fwd (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(d_valid_s1), .x(dx_s1), .y(dy_s1), .z(dz_s1), .tag(1'b1),
		.u_valid(f_valid), .ux(fx), .uy(fy), .uz(fz), .nz(f_nz), .u_tag(f_tag)
	);

	lab_cross #(.A_W(UNIT_W), .B_W(COORD_W), .TAG_W(T1W)) u_cross_up (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(f_valid), .ax(fx), .ay(fy), .az(fz),
		.bx(up_x_q), .by(up_y_q), .bz(up_z_q),
		.tag({f_tag[0] & f_nz, fx, fy, fz}),
		.c_valid(c1_valid), .cx(c1x), .cy(c1y), .cz(c1z), .c_tag(c1_tag)
	);

	lab_unit #(.IN_W(C1W), .TAG_W(T1W)) u_right (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(c1_valid), .x(c1x), .y(c1y), .z(c1z), .tag(c1_tag),
		.u_valid(r_valid), .ux(rx), .uy(ry), .uz(rz), .nz(r_nz), .u_tag(r_tag)
	);

	assign r_ok = r_tag[T1W-1] & r_nz;

	lab_cross #(.A_W(UNIT_W), .B_W(UNIT_W), .TAG_W(T2W)) u_cross_right (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(r_valid),
		.ax(unit_t'(r_tag[2*UNIT_W +: UNIT_W])),
		.ay(unit_t'(r_tag[UNIT_W +: UNIT_W])),
		.az(unit_t'(r_tag[0 +: UNIT_W])),
		.bx(rx), .by(ry), .bz(rz),
		.tag({r_ok, r_tag[3*UNIT_W-1:0], rx, ry, rz}),
		.c_valid(c2_valid), .cx(c2x), .cy(c2y), .cz(c2z), .c_tag(c2_tag)
	);

	lab_unit #(.IN_W(C2W), .TAG_W(T2W)) u_ortho (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid(c2_valid), .x(c2x), .y(c2y), .z(c2z), .tag(c2_tag),
		.u_valid(n_valid), .ux(nx), .uy(ny), .uz(nz), .nz(n_nz), .u_tag(n_tag)
	);

	assign ok = n_tag[T2W-1] & n_nz;

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.fwd_x      <= ok ? unit_t'(n_tag[5*UNIT_W +: UNIT_W]) : unit_t'(0);
			res_q.fwd_y      <= ok ? unit_t'(n_tag[4*UNIT_W +: UNIT_W]) : unit_t'(0);
			res_q.fwd_z      <= ok ? unit_t'(n_tag[3*UNIT_W +: UNIT_W]) : unit_t'(0);
			res_q.right_x    <= ok ? unit_t'(n_tag[2*UNIT_W +: UNIT_W]) : unit_t'(0);
			res_q.right_y    <= ok ? unit_t'(n_tag[UNIT_W +: UNIT_W]) : unit_t'(0);
			res_q.right_z    <= ok ? unit_t'(n_tag[0 +: UNIT_W]) : unit_t'(0);
			res_q.ortho_up_x <= ok ? nx : unit_t'(0);
			res_q.ortho_up_y <= ok ? ny : unit_t'(0);
			res_q.ortho_up_z <= ok ? nz : unit_t'(0);
			res_q.degenerate <= !ok;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

`ifndef SYNTHESIS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.degenerate |->
			res_data.fwd_x == 0 && res_data.fwd_y == 0 && res_data.fwd_z == 0 &&
			res_data.right_x == 0 && res_data.right_y == 0 && res_data.right_z == 0 &&
			res_data.ortho_up_x == 0 && res_data.ortho_up_y == 0 &&
			res_data.ortho_up_z == 0)
		else $error("degenerate result carries nonzero vectors");

	a_fwd_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.degenerate |->
			res_data.fwd_x <= UNIT_ONE && res_data.fwd_x >= -UNIT_ONE &&
			res_data.fwd_y <= UNIT_ONE && res_data.fwd_y >= -UNIT_ONE &&
			res_data.fwd_z <= UNIT_ONE && res_data.fwd_z >= -UNIT_ONE)
		else $error("forward component beyond unit range");

	a_fwd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.degenerate |->
			!(res_data.fwd_x == 0 && res_data.fwd_y == 0 && res_data.fwd_z == 0))
		else $error("valid basis with zero forward vector");
`endif

endmodule
